>>> design/ccps_pkg.sv
// Shared constants for the cubic curve point sampler.
// Holds configuration register indexes, register widths and reset values.
// No dependencies.
package ccps_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_KIND    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEGMENT_COUNT = 1'd1;

    // Curve kind codes.
    localparam logic KIND_BEZIER  = 1'b0;
    localparam logic KIND_BSPLINE = 1'b1;

    // Segment count register.
    localparam int SEG_BITS  = 6;
    localparam int SEG_RESET = 50;

    // Uniform B-spline weights carry a common factor of six.
    localparam int BSPL_DIV = 6;

endpackage

>>> design/cubic_curve_point_sampler.sv
// Cubic Bezier / uniform cubic B-spline point sampler, top level.
// Depends on ccps_pkg for register indexes, kind codes and reset values.
// Holds the parameter sequencer, the step divider and the eight-stage datapath.

// One input word carries four 2D control points; the block returns N+1 sampled
// points (N = segment_count, 0 counts as 1), one per clock while the output side
// takes them, with tlast on the final point. The sequencer issues one parameter
// value per cycle, while the output is not stalled, into an eight-stage
// pipeline (powers of t, weights, products, sums, scaling, output register); the
// next word is taken in the same cycle that the last point of the current one is
// issued. Writing segment_count starts a bit-serial division of 1.0 by N; no
// input word is taken while it runs. There is no clearing pass after reset.
module cubic_curve_point_sampler #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [ccps_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [ccps_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    // Control point stream.
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata, from bit 0: pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, pt4_x, pt4_y.
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    // Curve point stream.
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // tdata, from bit 0: curve_x, curve_y, zero fill.
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      o_m_tdata,
    output logic                                   o_m_tlast
);
    import ccps_pkg::*;

    localparam int C          = COORD_BITS;
    localparam int F          = FRAC_BITS;
    localparam int TB         = F + 1;          // Q1.F parameter width
    localparam int WB         = F + 3;          // weight width, up to 4.0
    localparam int WS         = F + 6;          // signed scratch for weights
    localparam int PB         = F + C + 4;      // product width
    localparam int AB         = PB + 2;         // sum width
    localparam int MB         = C + 2;          // magnitude after the 1.0 scale
    localparam int REC_K      = MB + 6;         // reciprocal shift
    localparam int QB         = MB + REC_K;     // reciprocal product width
    localparam int SB         = C + 3;          // signed width before saturation
    localparam int CNT_BITS   = $clog2(F + 1);
    localparam int OUT_TDATA  = ((2*COORD_BITS+7)/8)*8;

    localparam logic [TB-1:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic [TB-1:0] QUO_RST = TB'((2**F) / SEG_RESET);
    localparam logic [SEG_BITS-1:0] REM_RST = SEG_BITS'((2**F) % SEG_RESET);
    localparam longint REC_L = (longint'(1) << REC_K) / BSPL_DIV + 1;
    localparam logic [REC_K-3:0] REC_V = (REC_K-2)'(REC_L);
    localparam logic signed [SB-1:0] SAT_HI = SB'((longint'(1) << (C-1)) - 1);
    localparam logic signed [SB-1:0] SAT_LO = -SAT_HI - SB'(1);

    typedef logic signed [C-1:0] t_coord;

    // ------------------------------------------------------------------
    // Configuration registers and the step divider.
    logic                  r_kind;
    logic [SEG_BITS-1:0]   r_seg;
    logic [SEG_BITS-1:0]   seg_eff;
    logic                  r_div_busy;
    logic [CNT_BITS-1:0]   r_div_cnt;
    logic [SEG_BITS-1:0]   r_div_rem;
    logic [TB-1:0]         r_quo;
    logic [SEG_BITS:0]     div_shift;
    logic                  div_ge;

    assign seg_eff   = (r_seg == '0) ? SEG_BITS'(1) : r_seg;
    assign div_shift = {r_div_rem, (r_div_cnt == '0)};
    assign div_ge    = div_shift >= {1'b0, seg_eff};

    // The divider forms 1.0 / N one quotient bit per cycle, restoring form.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_BEZIER;
            r_seg      <= SEG_BITS'(SEG_RESET);
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
            r_div_rem  <= REM_RST;
            r_quo      <= QUO_RST;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_CURVE_KIND) begin
                r_kind <= i_cfg_data[0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_SEGMENT_COUNT) begin
                r_seg      <= i_cfg_data[SEG_BITS-1:0];
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
                r_div_rem  <= '0;
            end else if (r_div_busy) begin
                r_div_rem <= div_ge ? SEG_BITS'(div_shift - {1'b0, seg_eff})
                                    : div_shift[SEG_BITS-1:0];
                r_quo     <= {r_quo[TB-2:0], div_ge};
                r_div_cnt <= r_div_cnt + CNT_BITS'(1);
                if (r_div_cnt == CNT_BITS'(F)) begin
                    r_div_busy <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output word is stuck.
    logic r_out_valid;
    logic adv;
    assign adv = !r_out_valid || i_m_tready;

    // ------------------------------------------------------------------
    // Parameter sequencer: steps t = k/N by running quotient and remainder.
    logic                  r_busy;
    logic [SEG_BITS-1:0]   r_k;
    logic [TB-1:0]         r_t;
    logic [SEG_BITS-1:0]   r_r;
    t_coord                r_in_x [4];
    t_coord                r_in_y [4];
    logic                  seq_last;
    logic                  issue;
    logic                  accept;
    logic [SEG_BITS:0]     seq_sum;
    logic                  seq_wrap;

    assign seq_last   = (r_k == seg_eff);
    assign issue      = r_busy && adv;
    assign o_s_tready = !r_div_busy && (!r_busy || (adv && seq_last));
    assign accept     = i_s_tvalid && o_s_tready;
    assign seq_sum    = {1'b0, r_r} + {1'b0, r_div_rem};
    assign seq_wrap   = seq_sum >= {1'b0, seg_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (issue && seq_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_k <= '0;
            r_t <= '0;
            r_r <= '0;
            for (int i = 0; i < 4; i++) begin
                r_in_x[i] <= i_s_tdata[(2*i)*C +: C];
                r_in_y[i] <= i_s_tdata[(2*i+1)*C +: C];
            end
        end else if (issue) begin
            r_k <= r_k + SEG_BITS'(1);
            r_t <= r_t + r_quo + TB'(seq_wrap);
            r_r <= seq_wrap ? SEG_BITS'(seq_sum - {1'b0, seg_eff})
                            : seq_sum[SEG_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: T, S = 1 - T and their squares.
    logic                r_p1_valid, r_p1_last, r_p1_kind;
    t_coord              r_p1_x [4];
    t_coord              r_p1_y [4];
    logic [TB-1:0]       r_p1_t, r_p1_s, r_p1_t2, r_p1_s2;
    logic [TB-1:0]       s_now;
    logic [2*TB-1:0]     tt_prod, ss_prod;

    assign s_now   = ONE - r_t;
    assign tt_prod = (2*TB)'(r_t) * (2*TB)'(r_t);
    assign ss_prod = (2*TB)'(s_now) * (2*TB)'(s_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_last <= seq_last;
            r_p1_kind <= r_kind;
            r_p1_x    <= r_in_x;
            r_p1_y    <= r_in_y;
            r_p1_t    <= r_t;
            r_p1_s    <= s_now;
            r_p1_t2   <= tt_prod[2*F:F];
            r_p1_s2   <= ss_prod[2*F:F];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cubes and the two mixed terms of the Bezier basis.
    logic                r_p2_valid, r_p2_last, r_p2_kind;
    t_coord              r_p2_x [4];
    t_coord              r_p2_y [4];
    logic [TB-1:0]       r_p2_t, r_p2_t2, r_p2_t3, r_p2_s3, r_p2_u, r_p2_v;
    logic [2*TB-1:0]     t3_prod, s3_prod, u_prod, v_prod;

    assign t3_prod = (2*TB)'(r_p1_t2) * (2*TB)'(r_p1_t);
    assign s3_prod = (2*TB)'(r_p1_s2) * (2*TB)'(r_p1_s);
    assign u_prod  = (2*TB)'(r_p1_s2) * (2*TB)'(r_p1_t);
    assign v_prod  = (2*TB)'(r_p1_s)  * (2*TB)'(r_p1_t2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else if (adv) begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_last <= r_p1_last;
            r_p2_kind <= r_p1_kind;
            r_p2_x    <= r_p1_x;
            r_p2_y    <= r_p1_y;
            r_p2_t    <= r_p1_t;
            r_p2_t2   <= r_p1_t2;
            r_p2_t3   <= t3_prod[2*F:F];
            r_p2_s3   <= s3_prod[2*F:F];
            r_p2_u    <= u_prod[2*F:F];
            r_p2_v    <= v_prod[2*F:F];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: per-point weights for the selected basis.
    logic                r_p3_valid, r_p3_last, r_p3_kind;
    t_coord              r_p3_x [4];
    t_coord              r_p3_y [4];
    logic [WB-1:0]       r_p3_w [4];
    logic signed [WS-1:0] t1_s, t2_s, t3_s, wb_s, wc_s;
    logic [WB-1:0]       w_next [4];

    assign t1_s = $signed({5'b0, r_p2_t});
    assign t2_s = $signed({5'b0, r_p2_t2});
    assign t3_s = $signed({5'b0, r_p2_t3});
    assign wb_s = WS'(-3 * t3_s + 3 * t2_s + 3 * t1_s) + WS'(ONE);
    assign wc_s = WS'(3 * t3_s - 6 * t2_s) + WS'(4 * ONE);

    always_comb begin
        if (r_p2_kind == KIND_BSPLINE) begin
            w_next[0] = WB'(r_p2_t3);
            w_next[1] = wb_s[WB-1:0];
            w_next[2] = wc_s[WB-1:0];
            w_next[3] = WB'(r_p2_s3);
        end else begin
            w_next[0] = WB'(r_p2_s3);
            w_next[1] = (WB'(r_p2_u) << 1) + WB'(r_p2_u);
            w_next[2] = (WB'(r_p2_v) << 1) + WB'(r_p2_v);
            w_next[3] = WB'(r_p2_t3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else if (adv) begin
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_last <= r_p2_last;
            r_p3_kind <= r_p2_kind;
            r_p3_x    <= r_p2_x;
            r_p3_y    <= r_p2_y;
            r_p3_w    <= w_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: weight times coordinate, eight multipliers side by side.
    logic                r_p4_valid, r_p4_last, r_p4_kind;
    logic signed [PB-1:0] r_p4_px [4];
    logic signed [PB-1:0] r_p4_py [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else if (adv) begin
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4_last <= r_p3_last;
            r_p4_kind <= r_p3_kind;
            for (int i = 0; i < 4; i++) begin
                r_p4_px[i] <= PB'($signed({1'b0, r_p3_w[i]})) * PB'(r_p3_x[i]);
                r_p4_py[i] <= PB'($signed({1'b0, r_p3_w[i]})) * PB'(r_p3_y[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: exact sums of the four products.
    logic                r_p5_valid, r_p5_last, r_p5_kind;
    logic signed [AB-1:0] r_p5_ax, r_p5_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
        end else if (adv) begin
            r_p5_valid <= r_p4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5_last <= r_p4_last;
            r_p5_kind <= r_p4_kind;
            r_p5_ax   <= AB'(r_p4_px[0]) + AB'(r_p4_px[1])
                       + AB'(r_p4_px[2]) + AB'(r_p4_px[3]);
            r_p5_ay   <= AB'(r_p4_py[0]) + AB'(r_p4_py[1])
                       + AB'(r_p4_py[2]) + AB'(r_p4_py[3]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: sign and magnitude, then drop the fraction (toward zero).
    logic                r_p6_valid, r_p6_last, r_p6_kind;
    logic                r_p6_nx, r_p6_ny;
    logic [MB-1:0]       r_p6_mx, r_p6_my;
    logic [AB-1:0]       mag_x, mag_y;

    assign mag_x = r_p5_ax[AB-1] ? AB'(-r_p5_ax) : AB'(r_p5_ax);
    assign mag_y = r_p5_ay[AB-1] ? AB'(-r_p5_ay) : AB'(r_p5_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_valid <= 1'b0;
        end else if (adv) begin
            r_p6_valid <= r_p5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p6_last <= r_p5_last;
            r_p6_kind <= r_p5_kind;
            r_p6_nx   <= r_p5_ax[AB-1];
            r_p6_ny   <= r_p5_ay[AB-1];
            r_p6_mx   <= mag_x[F+MB-1:F];
            r_p6_my   <= mag_y[F+MB-1:F];
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: B-spline divide by six through a reciprocal multiply.
    logic                r_p7_valid, r_p7_last;
    logic                r_p7_nx, r_p7_ny;
    logic [MB-1:0]       r_p7_qx, r_p7_qy;
    logic [QB-1:0]       rec_x, rec_y;

    assign rec_x = QB'(r_p6_mx) * QB'(REC_V);
    assign rec_y = QB'(r_p6_my) * QB'(REC_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p7_valid <= 1'b0;
        end else if (adv) begin
            r_p7_valid <= r_p6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p7_last <= r_p6_last;
            r_p7_nx   <= r_p6_nx;
            r_p7_ny   <= r_p6_ny;
            r_p7_qx   <= (r_p6_kind == KIND_BSPLINE) ? rec_x[REC_K+MB-1:REC_K] : r_p6_mx;
            r_p7_qy   <= (r_p6_kind == KIND_BSPLINE) ? rec_y[REC_K+MB-1:REC_K] : r_p6_my;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: restore the sign, saturate, and hold the output word.
    logic                r_out_last;
    t_coord              r_out_x, r_out_y;
    logic signed [SB-1:0] sx, sy;
    t_coord              cx, cy;

    assign sx = r_p7_nx ? -$signed({1'b0, r_p7_qx}) : $signed({1'b0, r_p7_qx});
    assign sy = r_p7_ny ? -$signed({1'b0, r_p7_qy}) : $signed({1'b0, r_p7_qy});
    assign cx = (sx > SAT_HI) ? SAT_HI[C-1:0] : (sx < SAT_LO) ? SAT_LO[C-1:0] : sx[C-1:0];
    assign cy = (sy > SAT_HI) ? SAT_HI[C-1:0] : (sy < SAT_LO) ? SAT_LO[C-1:0] : sy[C-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_p7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_last <= r_p7_last;
            r_out_x    <= cx;
            r_out_y    <= cy;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = OUT_TDATA'({r_out_y, r_out_x});

    // ------------------------------------------------------------------
    // Checks on the sequencer and divider.
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_busy |-> !o_s_tready)
        else $error("input taken while the step divider runs");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_busy && r_k == '0 && r_t == '0))
        else $error("accepted word did not start a fresh run");

    a_last_at_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && seq_last) |-> (r_t == ONE))
        else $error("parameter did not reach 1.0 on the last sample");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the cubic curve point sampler.
// Sends control-point words, predicts every sampled point and checks the output stream.
// Depends on ccps_pkg and the cubic_curve_point_sampler top level.
module tb_top;
    import ccps_pkg::*;

    localparam int     COORD_W       = 12;
    localparam int     FRAC_W        = 16;
    localparam longint ONE           = longint'(1) << FRAC_W;
    localparam longint COORD_MAX     = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;
    localparam int     IN_W          = ((8*COORD_W+7)/8)*8;
    localparam int     OUT_W         = ((2*COORD_W+7)/8)*8;
    localparam int     MAX_GAP       = 18;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint CYCLE_LIMIT   = 2_000_000;
    localparam int     MAX_REPORTS   = 10;
    localparam int     RAND_PHASES   = 12;
    localparam int     PHASE_WORDS   = 26;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct {
        t_coord px[4];
        t_coord py[4];
    } t_ctrl_set;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_curve_pt;

    // Block inputs, all known from time zero.
    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic [IN_W-1:0]          s_tdata  = '0;
    logic                     m_tready = 1'b0;

    // Block outputs.
    logic                     s_tready;
    logic                     m_tvalid;
    logic [OUT_W-1:0]         m_tdata;
    logic                     m_tlast;

    // Shadow copy of the configuration registers.
    logic                     shadow_kind = KIND_BEZIER;
    logic [SEG_BITS-1:0]      shadow_segs = SEG_BITS'(SEG_RESET);

    // Expected curve points, oldest first.
    t_curve_pt curve_pts_q[$];

    bit     src_idle_on   = 1'b1;
    bit     sink_idle_on  = 1'b1;
    int     sink_hold_len = 0;
    int     mismatches    = 0;
    longint cycle_cnt     = 0;

    always #1 clk = ~clk;

    cubic_curve_point_sampler #(
        .COORD_BITS (COORD_W),
        .FRAC_BITS  (FRAC_W)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // One coordinate of a curve point at parameter t (unsigned Q1.16).
    // Every power is truncated back to Q1.16 after each multiply.
    function automatic t_coord blend_axis(logic kind, longint t,
                                          longint a, longint b, longint c, longint d);
        longint s, t2, t3, s2, s3, acc, q;
        s  = ONE - t;
        t2 = (t * t) >>> FRAC_W;
        t3 = (t2 * t) >>> FRAC_W;
        s2 = (s * s) >>> FRAC_W;
        s3 = (s2 * s) >>> FRAC_W;
        if (kind == KIND_BSPLINE) begin
            // The fourth point takes the (1-t)^3 weight, the first one t^3.
            acc = s3 * d + (3 * t3 - 6 * t2 + 4 * ONE) * c
                + (-3 * t3 + 3 * t2 + 3 * t + ONE) * b + t3 * a;
            q = acc / (BSPL_DIV * ONE);
        end else begin
            acc = s3 * a + 3 * ((s2 * t) >>> FRAC_W) * b
                + 3 * ((s * t2) >>> FRAC_W) * c + t3 * d;
            q = acc / ONE;
        end
        if (q > COORD_MAX) q = COORD_MAX;
        if (q < COORD_MIN) q = COORD_MIN;
        return t_coord'(q);
    endfunction

    // Queue the polyline that one control set yields under the current settings.
    // t advances by a running quotient and remainder, so it ends exactly on 1.0.
    function automatic void predict_polyline(t_ctrl_set cs);
        longint    n, quo, rem, t, r;
        t_curve_pt pt;
        n   = (shadow_segs == 0) ? 1 : longint'(shadow_segs);
        quo = ONE / n;
        rem = ONE % n;
        t   = 0;
        r   = 0;
        for (longint k = 0; k <= n; k++) begin
            pt.x    = blend_axis(shadow_kind, t, cs.px[0], cs.px[1], cs.px[2], cs.px[3]);
            pt.y    = blend_axis(shadow_kind, t, cs.py[0], cs.py[1], cs.py[2], cs.py[3]);
            pt.last = (k == n);
            curve_pts_q = {curve_pts_q, pt};
            t += quo;
            r += rem;
            if (r >= n) begin
                r -= n;
                t += 1;
            end
        end
    endfunction

    function automatic logic [IN_W-1:0] pack_ctrl(t_ctrl_set cs);
        logic [IN_W-1:0] w;
        w = '0;
        for (int i = 0; i < 4; i++) begin
            w[2*COORD_W*i +: COORD_W]         = cs.px[i];
            w[2*COORD_W*i+COORD_W +: COORD_W] = cs.py[i];
        end
        return w;
    endfunction

    // Even points get (a, b) and odd points get (b, a).
    function automatic t_ctrl_set alternating_ctrl(t_coord a, t_coord b);
        t_ctrl_set cs;
        for (int i = 0; i < 4; i++) begin
            cs.px[i] = (i % 2 == 0) ? a : b;
            cs.py[i] = (i % 2 == 0) ? b : a;
        end
        return cs;
    endfunction

    // Random coordinate, leaning on the range ends and zero now and then.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0: return t_coord'(COORD_MIN);
            1: return t_coord'(COORD_MAX);
            2: return '0;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_ctrl_set rand_ctrl();
        t_ctrl_set cs;
        for (int i = 0; i < 4; i++) begin
            cs.px[i] = rand_coord();
            cs.py[i] = rand_coord();
        end
        return cs;
    endfunction

    function automatic int draw_gap(bit enabled);
        return enabled ? int'($urandom_range(0, MAX_GAP)) : 0;
    endfunction

    // Offer one control-point word and queue its points once it is taken.
    task automatic send_ctrl(t_ctrl_set cs);
        int gap;
        gap = draw_gap(src_idle_on);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_ctrl(cs);
        do @(posedge clk); while (!s_tready);
        predict_polyline(cs);
    endtask

    // Stop offering words and wait until every expected point has come out.
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (curve_pts_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_CURVE_KIND:    shadow_kind = data[0];
            CFG_SEGMENT_COUNT: shadow_segs = data[SEG_BITS-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits are junk here; only bit 0 selects the curve kind.
    task automatic set_kind(logic kind);
        logic [CFG_DATA_BITS-1:0] data;
        data    = CFG_DATA_BITS'($urandom);
        data[0] = kind;
        write_reg(CFG_CURVE_KIND, data);
    endtask

    task automatic set_segs(int n);
        write_reg(CFG_SEGMENT_COUNT, CFG_DATA_BITS'(n));
    endtask

    task automatic report_mismatch(string what, t_curve_pt want, t_curve_pt got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     what, $signed(want.x), $signed(want.y), want.last,
                     $signed(got.x), $signed(got.y), got.last);
    endtask

    // Reset settings: Bezier over 50 steps, range ends and bit patterns.
    task automatic test_reset_defaults();
        send_ctrl(alternating_ctrl(t_coord'(COORD_MIN), t_coord'(COORD_MIN)));
        send_ctrl(alternating_ctrl(t_coord'(COORD_MAX), t_coord'(COORD_MAX)));
        send_ctrl(alternating_ctrl(t_coord'(COORD_MIN), t_coord'(COORD_MAX)));
        send_ctrl(alternating_ctrl(t_coord'(12'haaa), t_coord'(12'h555)));
        wait_drain();
    endtask

    // B-spline at the largest step count with extreme control points.
    task automatic test_bspline_extremes();
        set_kind(KIND_BSPLINE);
        set_segs((1 << SEG_BITS) - 1);
        send_ctrl(alternating_ctrl(t_coord'(COORD_MIN), t_coord'(COORD_MIN)));
        send_ctrl(alternating_ctrl(t_coord'(COORD_MAX), t_coord'(COORD_MAX)));
        send_ctrl(alternating_ctrl(t_coord'(COORD_MAX), t_coord'(COORD_MIN)));
        send_ctrl(alternating_ctrl(t_coord'(12'h555), t_coord'(12'haaa)));
        wait_drain();
    endtask

    // A step count of zero behaves as one; check it and one itself in both kinds.
    task automatic test_short_polylines();
        for (int kind = 0; kind < 2; kind++) begin
            set_kind(kind ? KIND_BSPLINE : KIND_BEZIER);
            set_segs(0);
            send_ctrl(rand_ctrl());
            send_ctrl(alternating_ctrl(t_coord'(COORD_MIN), t_coord'(COORD_MAX)));
            wait_drain();
            set_segs(1);
            send_ctrl(rand_ctrl());
            send_ctrl(alternating_ctrl(t_coord'(COORD_MAX), t_coord'(COORD_MIN)));
            wait_drain();
        end
    endtask

    // Random control sets over several settings, mostly short polylines.
    task automatic test_random_phases();
        int n;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_kind($urandom_range(0, 1) ? KIND_BSPLINE : KIND_BEZIER);
            case ($urandom_range(0, 19))
                0:             n = 0;
                1, 2:          n = int'($urandom_range(31, 63));
                3, 4, 5, 6, 7: n = int'($urandom_range(9, 30));
                default:       n = int'($urandom_range(1, 8));
            endcase
            set_segs(n);
            src_idle_on  = (ph != 0) && ($urandom_range(0, 3) != 0);
            sink_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_WORDS) send_ctrl(rand_ctrl());
            wait_drain();
        end
    endtask

    // The receiver holds off long enough to fill the block and stall its input,
    // then the sender pauses until every point has drained.
    task automatic test_backpressure();
        set_kind(KIND_BEZIER);
        set_segs(4);
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b1;
        sink_hold_len = HOLD_CYCLES;
        repeat (20) send_ctrl(rand_ctrl());
        wait_drain();
        src_idle_on = 1'b1;
        repeat (10) send_ctrl(rand_ctrl());
        wait_drain();
    endtask

    // Receiver: draws a stall before each word, or takes a long hold when asked.
    initial begin
        int stall;
        forever begin
            @(negedge clk);
            stall = (sink_hold_len > 0) ? sink_hold_len : draw_gap(sink_idle_on);
            sink_hold_len = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Compare each accepted curve point with the oldest expected one.
    always @(posedge clk) begin : check_points
        t_curve_pt got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got.x    = m_tdata[COORD_W-1:0];
            got.y    = m_tdata[2*COORD_W-1:COORD_W];
            got.last = m_tlast;
            if (curve_pts_q.size() == 0) begin
                report_mismatch("unexpected point", '0, got);
            end else begin
                want = curve_pts_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
                    report_mismatch("point mismatch", want, got);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_bspline_extremes();
        test_short_polylines();
        test_random_phases();
        test_backpressure();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
